// ===== design/u8u16_pkg.sv =====
// u8u16_pkg: shared types and constants for the utf-8 to utf-16 transcoder
// used by u8u16_decoder, u8u16_result_fifo and utf8_to_utf16_transcoder_core
package u8u16_pkg;

	// result kinds as they appear on the output
	typedef enum logic [1:0] {
		KIND_UNIT    = 2'd0,
		KIND_OK      = 2'd1,
		KIND_INVALID = 2'd2,
		KIND_LIMIT   = 2'd3
	} kind_t;

	// sticky per-string error codes, same encoding as the status kinds
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_INVALID = 2'd2;
	localparam logic [1:0] ERR_LIMIT   = 2'd3;

	localparam logic [15:0] MAX_UNITS_RESET = 16'hFFFF;

	// result queue depth; one byte can push up to three results
	localparam int RESULTS_PER_BYTE = 3;
	localparam int FIFO_DEPTH       = 4;

	localparam logic [20:0] SCALAR_2B_MIN  = 21'h000080;
	localparam logic [20:0] SCALAR_3B_MIN  = 21'h000800;
	localparam logic [20:0] SCALAR_4B_MIN  = 21'h010000;
	localparam logic [20:0] SCALAR_MAX     = 21'h10FFFF;
	localparam logic [20:0] SURR_LOW       = 21'h00D800;
	localparam logic [20:0] SURR_HIGH      = 21'h00DFFF;
	localparam logic [20:0] BMP_MAX        = 21'h00FFFF;
	localparam logic [15:0] HI_SURR_BASE   = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE   = 16'hDC00;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} in_t;

	typedef struct packed {
		logic [15:0] code_unit;
		kind_t       kind;
		logic        last;
	} out_t;

	// results produced by one byte, item[0] goes out first
	typedef struct packed {
		logic [1:0] n;
		out_t [2:0] item;
	} push_t;

endpackage

// ===== design/u8u16_decoder.sv =====
// u8u16_decoder: per-string utf-8 state and combinational decode of one byte
// into up to three results; depends on u8u16_pkg
module u8u16_decoder (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  u8u16_pkg::in_t         item,
	input  logic [15:0]            max_units,
	output u8u16_pkg::push_t       push
);

	logic [20:0] partial_q;
	logic [1:0]  pend_q;
	logic [1:0]  seqlen_q;
	logic [16:0] units_q;
	logic [1:0]  err_q;

	logic [20:0] partial_n;
	logic [1:0]  pend_n;
	logic [1:0]  seqlen_n;
	logic [16:0] units_n;
	logic [1:0]  err_n;

	always_comb begin
		logic [7:0]  b;
		logic        fin;
		logic [20:0] scalar;
		logic [1:0]  conts;
		logic        bad;
		logic        two;
		logic [16:0] room;
		logic        fits;
		logic [20:0] adj;
		logic [1:0]  n;
		b         = item.data_byte;
		fin       = 1'b0;
		scalar    = '0;
		conts     = '0;
		bad       = 1'b0;
		two       = 1'b0;
		room      = '0;
		fits      = 1'b0;
		adj       = '0;
		n         = '0;
		push      = '0;
		partial_n = partial_q;
		pend_n    = pend_q;
		seqlen_n  = seqlen_q;
		units_n   = units_q;
		err_n     = err_q;

		if (err_q == u8u16_pkg::ERR_NONE) begin
			if (pend_q == 2'd0) begin
				priority if (b <= 8'h7F) begin
					fin    = 1'b1;
					scalar = {13'b0, b};
					conts  = 2'd0;
				end else if (b >= 8'hC2 && b <= 8'hDF) begin
					partial_n = {16'b0, b[4:0]};
					pend_n    = 2'd1;
					seqlen_n  = 2'd1;
				end else if (b >= 8'hE0 && b <= 8'hEF) begin
					partial_n = {17'b0, b[3:0]};
					pend_n    = 2'd2;
					seqlen_n  = 2'd2;
				end else if (b >= 8'hF0 && b <= 8'hF4) begin
					partial_n = {18'b0, b[2:0]};
					pend_n    = 2'd3;
					seqlen_n  = 2'd3;
				end else begin
					err_n = u8u16_pkg::ERR_INVALID;
				end
			end else if (b[7:6] != 2'b10) begin
				err_n = u8u16_pkg::ERR_INVALID;
			end else begin
				partial_n = {partial_q[14:0], b[5:0]};
				pend_n    = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					fin    = 1'b1;
					scalar = {partial_q[14:0], b[5:0]};
					conts  = seqlen_q;
				end
			end
		end

		if (fin) begin
			bad = (conts == 2'd1 && scalar < u8u16_pkg::SCALAR_2B_MIN) ||
				(conts == 2'd2 && scalar < u8u16_pkg::SCALAR_3B_MIN) ||
				(conts == 2'd3 && scalar < u8u16_pkg::SCALAR_4B_MIN) ||
				(scalar > u8u16_pkg::SCALAR_MAX) ||
				(scalar >= u8u16_pkg::SURR_LOW && scalar <= u8u16_pkg::SURR_HIGH);
			two  = scalar > u8u16_pkg::BMP_MAX;
			// headroom left under the limit, only meaningful when not already over
			room = {1'b0, max_units} - units_q;
			fits = (units_q <= {1'b0, max_units}) &&
				(two ? (room >= 17'd2) : (room >= 17'd1));
			adj  = scalar - u8u16_pkg::SCALAR_4B_MIN;
			if (bad) begin
				err_n = u8u16_pkg::ERR_INVALID;
			end else if (!fits) begin
				err_n = u8u16_pkg::ERR_LIMIT;
			end else if (!two) begin
				push.item[0].code_unit = scalar[15:0];
				push.item[0].kind      = u8u16_pkg::KIND_UNIT;
				push.item[0].last      = 1'b0;
				n       = 2'd1;
				units_n = units_q + 17'd1;
			end else begin
				push.item[0].code_unit = u8u16_pkg::HI_SURR_BASE + {6'b0, adj[19:10]};
				push.item[0].kind      = u8u16_pkg::KIND_UNIT;
				push.item[0].last      = 1'b0;
				push.item[1].code_unit = u8u16_pkg::LO_SURR_BASE + {6'b0, adj[9:0]};
				push.item[1].kind      = u8u16_pkg::KIND_UNIT;
				push.item[1].last      = 1'b0;
				n       = 2'd2;
				units_n = units_q + 17'd2;
			end
		end

		if (item.end_of_string) begin
			// truncated sequence at the flagged byte
			if (err_n == u8u16_pkg::ERR_NONE && pend_n != 2'd0) begin
				err_n = u8u16_pkg::ERR_INVALID;
			end
			push.item[n].code_unit = 16'h0000;
			push.item[n].kind      = (err_n == u8u16_pkg::ERR_NONE) ?
				u8u16_pkg::KIND_OK : u8u16_pkg::kind_t'(err_n);
			push.item[n].last      = 1'b1;
			n         = n + 2'd1;
			partial_n = '0;
			pend_n    = '0;
			seqlen_n  = '0;
			units_n   = '0;
			err_n     = u8u16_pkg::ERR_NONE;
		end

		push.n = en ? n : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pend_q    <= '0;
			seqlen_q  <= '0;
			units_q   <= '0;
			err_q     <= u8u16_pkg::ERR_NONE;
		end else if (en) begin
			partial_q <= partial_n;
			pend_q    <= pend_n;
			seqlen_q  <= seqlen_n;
			units_q   <= units_n;
			err_q     <= err_n;
		end
	end

	// the flagged byte clears all per-string state
	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.end_of_string |=>
			pend_q == 2'd0 && units_q == 17'd0 && err_q == u8u16_pkg::ERR_NONE)
		else $error("string state not cleared after end of string");

	// a sticky error suppresses every result but the final status
	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		en && err_q != u8u16_pkg::ERR_NONE && !item.end_of_string |-> push.n == 2'd0)
		else $error("result emitted after sticky error");

	// status result always comes last and only on the flagged byte
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.end_of_string |->
			push.n != 2'd0 && push.item[push.n - 2'd1].last)
		else $error("missing status result on end of string");

endmodule

// ===== design/u8u16_result_fifo.sv =====
// u8u16_result_fifo: small result queue taking up to three results per cycle and
// delivering one per cycle on the output while out_stall is low; uses u8u16_pkg
module u8u16_result_fifo #(
	parameter int DEPTH = u8u16_pkg::FIFO_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  u8u16_pkg::push_t       push,
	output logic                   room,
	output logic                   out_valid,
	input  logic                   out_stall,
	output u8u16_pkg::out_t        out_data
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	u8u16_pkg::out_t mem_q [DEPTH];
	logic [IW-1:0]   rd_q;
	logic [IW-1:0]   wr_q;
	logic [CW-1:0]   cnt_q;
	logic            pop;

	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] p, input logic [1:0] k);
		logic [IW:0] s;
		s = {1'b0, p} + {{(IW - 1){1'b0}}, k};
		if (s >= (IW + 1)'(DEPTH)) begin
			s = s - (IW + 1)'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && !out_stall;
	// space for a full three-result push after this cycle's pop
	assign room      = cnt_q <= CW'(DEPTH - u8u16_pkg::RESULTS_PER_BYTE) + CW'(pop);

	always_ff @(posedge clk) begin
		for (int k = 0; k < u8u16_pkg::RESULTS_PER_BYTE; k++) begin
			if (2'(k) < push.n) begin
				mem_q[wrap_add(wr_q, 2'(k))] <= push.item[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wrap_add(wr_q, push.n);
			if (pop) begin
				rd_q <= wrap_add(rd_q, 2'd1);
			end
			cnt_q <= cnt_q + CW'(push.n) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(CW + 1)'(cnt_q) + (CW + 1)'(push.n) <= (CW + 1)'(DEPTH) + (CW + 1)'(pop))
		else $error("result queue overflow");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("result queue count out of range");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> $past(1'b1) && cnt_q <= CW'(DEPTH - 1) + CW'(pop))
		else $error("push into a full queue");

endmodule

// ===== design/utf8_to_utf16_transcoder_core.sv =====
// utf8_to_utf16_transcoder_core: top level of the strict utf-8 to utf-16 transcoder
// depends on u8u16_pkg, u8u16_decoder and u8u16_result_fifo

// Bytes of a utf-8 string enter one per request on the input channel, the final
// byte flagged by end_of_string. Each byte is registered, then decoded
// combinationally against the per-string state, producing zero to three results
// (up to two utf-16 code units, then one status result with last set on the
// flagged byte) that go into a small result queue read one per cycle on the
// output channel while out_stall is low. The input takes one byte per cycle as
// long as results drain one per cycle; a byte that makes more than one result
// (a surrogate pair or a status) holds the input for the extra output cycles,
// set by the single output port of the result queue. max_units is written
// through wr_en/wr_data and takes effect at the next limit check.
module utf8_to_utf16_transcoder_core #(
	parameter int FIFO_DEPTH = u8u16_pkg::FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  u8u16_pkg::in_t    in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output u8u16_pkg::out_t   out_data,
	input  logic              wr_en,
	input  logic [15:0]       wr_data
);

	logic             valid_s1;
	u8u16_pkg::in_t   item_s1;
	logic [15:0]      max_units_q;
	logic             room;
	logic             proc;
	logic             accept;
	u8u16_pkg::push_t push;

	assign proc     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_units_q <= u8u16_pkg::MAX_UNITS_RESET;
		end else if (wr_en) begin
			max_units_q <= wr_data;
		end
	end

	u8u16_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (proc),
		.item      (item_s1),
		.max_units (max_units_q),
		.push      (push)
	);

	u8u16_result_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
